// File: src/cfwr_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and index helpers for the circular FIFO with reverse.
// No dependencies; cfwr_dp, cfwr_ctrl, the core and the checker import this package.
package cfwr_pkg;

    localparam int DEPTH = 16;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CAP_W = 5;
    localparam int FILL_W = 5;
    localparam int DATA_W = 32;

    typedef enum logic [1:0] {
        OP_ENQ  = 2'd0,
        OP_DEQ  = 2'd1,
        OP_REV  = 2'd2,
        OP_PEEK = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_DEQ,
        S_RLOOP,
        S_RWA,
        S_RWB,
        S_HEAD,
        S_DONE
    } state_t;

    typedef struct packed {
        op_t                      op;
        logic signed [DATA_W-1:0] value;
    } cmd_t;

    typedef struct packed {
        status_t                  status;
        logic signed [DATA_W-1:0] taken_value;
        logic signed [DATA_W-1:0] head_value;
        logic                     head_valid;
        logic [FILL_W-1:0]        fill_count;
        logic                     is_full;
    } result_t;

    // controller -> datapath
    typedef struct packed {
        logic    load;
        logic    enq;
        logic    set_status;
        status_t status_code;
        logic    rd_head;
        logic    deq_commit;
        logic    rev_init;
        logic    rd_pair;
        logic    wr_a;
        logic    wr_b_step;
    } dp_ctrl_t;

    // datapath -> controller
    typedef struct packed {
        op_t  op;
        logic empty;
        logic full;
        logic pairs_zero;
    } dp_stat_t;

    function automatic logic [IDX_W-1:0] step_up(logic [IDX_W-1:0] i, logic [CNT_W-1:0] cap);
        logic [CNT_W-1:0] nx;
        nx = CNT_W'(i) + CNT_W'(1);
        if (nx >= cap) begin
            return '0;
        end
        return IDX_W'(nx);
    endfunction

    function automatic logic [IDX_W-1:0] step_down(logic [IDX_W-1:0] i, logic [CNT_W-1:0] cap);
        logic [CNT_W-1:0] pv;
        pv = cap - CNT_W'(1);
        if (i == '0) begin
            return IDX_W'(pv);
        end
        return i - IDX_W'(1);
    endfunction

    // capacity register clamp: 0 acts as 1, above DEPTH acts as DEPTH
    function automatic logic [CNT_W-1:0] clamp_cap(logic [CAP_W-1:0] c);
        if (c == '0) begin
            return CNT_W'(1);
        end
        if (int'(c) > DEPTH) begin
            return CNT_W'(DEPTH);
        end
        return CNT_W'(c);
    endfunction

endpackage

// File: src/cfwr_ram.sv
`timescale 1ns / 1ps
// Generic RAM: one write port, two read ports with registered, enabled read data.
// No dependencies.
module cfwr_ram #(
    parameter int WORDS  = 16,
    parameter int WIDTH  = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(WORDS)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re_a,
    input  logic [$clog2(WORDS)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic                     re_b,
    input  logic [$clog2(WORDS)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [WORDS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re_a)
        begin
            rdata_a <= mem[raddr_a];
        end
        if (re_b)
        begin
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

// File: src/cfwr_dp.sv
`timescale 1ns / 1ps
// Datapath: pointers, fill count, capacity register, swap walker and entry RAM.
// Depends on cfwr_pkg and cfwr_ram.
module cfwr_dp
    import cfwr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  cmd_t             cmd,
    input  logic             cfg_we,
    input  logic [CAP_W-1:0] cfg_wdata,
    input  dp_ctrl_t         ctrl,
    output dp_stat_t         stat,
    output result_t          result
);

    op_t                 op_reg, op_next;
    logic [DATA_W-1:0]   value_reg, value_next;
    logic [IDX_W-1:0]    head_reg, head_next;
    logic [IDX_W-1:0]    tail_reg, tail_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    cap_reg, cap_next;
    logic [IDX_W-1:0]    a_reg, a_next;
    logic [IDX_W-1:0]    b_reg, b_next;
    logic [CNT_W-1:0]    pairs_reg, pairs_next;
    status_t             status_reg, status_next;
    logic [DATA_W-1:0]   taken_reg, taken_next;

    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr;
    logic [DATA_W-1:0]   ram_wdata;
    logic                ram_re_a;
    logic [IDX_W-1:0]    ram_raddr_a;
    logic [DATA_W-1:0]   rd_a;
    logic [DATA_W-1:0]   rd_b;
    logic [CNT_W-1:0]    cfg_cap;

    assign cfg_cap = clamp_cap(cfg_wdata);

    always_comb
    begin
        op_next     = op_reg;
        value_next  = value_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        cap_next    = cap_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        pairs_next  = pairs_reg;
        status_next = status_reg;
        taken_next  = taken_reg;

        if (cfg_we)
        begin
            // new capacity empties the FIFO
            cap_next   = cfg_cap;
            head_next  = '0;
            tail_next  = IDX_W'(cfg_cap - CNT_W'(1));
            count_next = '0;
        end
        if (ctrl.load)
        begin
            op_next     = cmd.op;
            value_next  = cmd.value;
            status_next = ST_DONE;
            taken_next  = '0;
        end
        if (ctrl.set_status)
        begin
            status_next = ctrl.status_code;
        end
        if (ctrl.enq)
        begin
            tail_next  = step_up(tail_reg, cap_reg);
            count_next = count_reg + CNT_W'(1);
        end
        if (ctrl.deq_commit)
        begin
            taken_next = rd_a;
            head_next  = step_up(head_reg, cap_reg);
            count_next = count_reg - CNT_W'(1);
        end
        if (ctrl.rev_init)
        begin
            a_next     = head_reg;
            b_next     = tail_reg;
            pairs_next = count_reg >> 1;
        end
        if (ctrl.wr_b_step)
        begin
            a_next     = step_up(a_reg, cap_reg);
            b_next     = step_down(b_reg, cap_reg);
            pairs_next = pairs_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg   <= '0;
            tail_reg   <= IDX_W'(DEPTH - 1);
            count_reg  <= '0;
            cap_reg    <= CNT_W'(DEPTH);
            status_reg <= ST_DONE;
            op_reg     <= OP_PEEK;
            pairs_reg  <= '0;
        end
        else
        begin
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            count_reg  <= count_next;
            cap_reg    <= cap_next;
            status_reg <= status_next;
            op_reg     <= op_next;
            pairs_reg  <= pairs_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        taken_reg <= taken_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
    end

    // write port: enqueue at next tail, or one half of a swap
    assign ram_we      = ctrl.enq | ctrl.wr_a | ctrl.wr_b_step;
    assign ram_waddr   = ctrl.enq ? step_up(tail_reg, cap_reg) : (ctrl.wr_a ? a_reg : b_reg);
    assign ram_wdata   = ctrl.enq ? value_reg : (ctrl.wr_a ? rd_b : rd_a);
    assign ram_re_a    = ctrl.rd_head | ctrl.rd_pair;
    assign ram_raddr_a = ctrl.rd_pair ? a_reg : head_reg;

    cfwr_ram #(
        .WORDS (DEPTH),
        .WIDTH (DATA_W)
    ) u_ram (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .re_a    (ram_re_a),
        .raddr_a (ram_raddr_a),
        .rdata_a (rd_a),
        .re_b    (ctrl.rd_pair),
        .raddr_b (b_reg),
        .rdata_b (rd_b)
    );

    assign stat.op         = op_reg;
    assign stat.empty      = (count_reg == '0);
    assign stat.full       = (count_reg >= cap_reg);
    assign stat.pairs_zero = (pairs_reg == '0);

    assign result.status      = status_reg;
    assign result.taken_value = taken_reg;
    assign result.head_value  = (count_reg != '0) ? rd_a : '0;
    assign result.head_valid  = (count_reg != '0);
    assign result.fill_count  = FILL_W'(count_reg);
    assign result.is_full     = (count_reg == cap_reg);

endmodule

// File: src/cfwr_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine: sequences enqueue, dequeue, reverse swaps and result.
// Depends on cfwr_pkg.
module cfwr_ctrl
    import cfwr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  dp_stat_t stat,
    output dp_ctrl_t ctrl,
    output logic     busy,
    output logic     done
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (stat.op == OP_DEQ && !stat.empty)
                begin
                    state_next = S_DEQ;
                end
                else if (stat.op == OP_REV && !stat.empty)
                begin
                    state_next = S_RLOOP;
                end
                else
                begin
                    state_next = S_HEAD;
                end
            end
            S_DEQ:   state_next = S_HEAD;
            S_RLOOP: state_next = stat.pairs_zero ? S_HEAD : S_RWA;
            S_RWA:   state_next = S_RWB;
            S_RWB:   state_next = S_RLOOP;
            S_HEAD:  state_next = S_DONE;
            S_DONE:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        ctrl = '0;
        ctrl.status_code = ST_DONE;
        busy = 1'b1;
        done = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                busy      = 1'b0;
                ctrl.load = start;
            end
            S_DECIDE:
            begin
                case (stat.op)
                    OP_ENQ:
                    begin
                        if (stat.full)
                        begin
                            ctrl.set_status  = 1'b1;
                            ctrl.status_code = ST_FULL;
                        end
                        else
                        begin
                            ctrl.enq = 1'b1;
                        end
                    end
                    OP_DEQ:
                    begin
                        if (stat.empty)
                        begin
                            ctrl.set_status  = 1'b1;
                            ctrl.status_code = ST_EMPTY;
                        end
                        else
                        begin
                            ctrl.rd_head = 1'b1;
                        end
                    end
                    OP_REV:
                    begin
                        if (stat.empty)
                        begin
                            ctrl.set_status  = 1'b1;
                            ctrl.status_code = ST_EMPTY;
                        end
                        else
                        begin
                            ctrl.rev_init = 1'b1;
                        end
                    end
                    default:
                    begin
                        ctrl.set_status = 1'b0;
                    end
                endcase
            end
            S_DEQ:   ctrl.deq_commit = 1'b1;
            S_RLOOP: ctrl.rd_pair    = !stat.pairs_zero;
            S_RWA:   ctrl.wr_a       = 1'b1;
            S_RWB:   ctrl.wr_b_step  = 1'b1;
            S_HEAD:  ctrl.rd_head    = 1'b1;
            S_DONE:  done            = 1'b1;
            default: busy            = 1'b1;
        endcase
    end

endmodule

// File: src/circular_fifo_with_reverse_core.sv
`timescale 1ns / 1ps
// Sequence: accept, decide, head read, then result strobe for enqueue, peek and rejects;
//   dequeue adds a commit state before the head read; reverse adds N = fill_count/2
//   swaps, each a paired read on the entry RAM, then one write per side.
// A new command is accepted only once the block is back in idle after the strobe.
// Reset: asynchronous, active low; FIFO empty, capacity 16. Receiver cannot stall.
module circular_fifo_with_reverse_core
    import cfwr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    // command channel: beat taken when start is high and busy is low
    input  logic             start,
    output logic             busy,
    input  cmd_t             cmd,
    // capacity register, written only while idle by the user (not enforced by the block); any write empties the FIFO
    input  logic             cfg_we,
    input  logic [CAP_W-1:0] cfg_wdata,
    // result beat: one cycle, no backpressure
    output logic             result_valid,
    output result_t          result
);

    dp_ctrl_t ctrl;
    dp_stat_t stat;

    // Controller only sequences; all pointer math and storage live in the datapath.
    cfwr_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .ctrl  (ctrl),
        .busy  (busy),
        .done  (result_valid)
    );

    // Datapath holds head/tail/count, the clamped capacity, the swap walker
    // (a/b pointers and remaining pair count) and the two-read-port entry RAM.
    // Result fields come straight from its registers during the done cycle.
    cfwr_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .ctrl      (ctrl),
        .stat      (stat),
        .result    (result)
    );

endmodule

// File: src/cfwr_chk.sv
`timescale 1ns / 1ps
// Port-level checker for the circular FIFO core, bound to the top level.
// Depends on cfwr_pkg.
module cfwr_chk
    import cfwr_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    start,
    input logic    busy,
    input logic    result_valid,
    input result_t result
);

    // result beat is a single-cycle pulse
    a_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result strobe longer than one cycle");

    // an accepted command makes the block busy
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("command accepted but busy not raised");

    a_hvalid: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.head_valid == (result.fill_count != '0)))
        else $error("head_valid disagrees with fill_count");

    a_hzero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.head_valid) |-> (result.head_value == '0))
        else $error("head_value nonzero while empty");

    a_taken: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.status != ST_DONE) |-> (result.taken_value == '0))
        else $error("rejected beat carries a taken value");

endmodule

bind circular_fifo_with_reverse_core cfwr_chk u_cfwr_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result_valid (result_valid),
    .result       (result)
);
